/* sv/tps_pkg.sv */
package tps_pkg;

    localparam int CoordW = 32;
    localparam int DiffW  = 33;
    localparam int ProdW  = 64;
    localparam int DivBits = 2;

    typedef struct packed {
        logic signed [31:0] vert0_x;
        logic signed [31:0] vert0_y;
        logic signed [31:0] vert0_z;
        logic signed [31:0] vert1_x;
        logic signed [31:0] vert1_y;
        logic signed [31:0] vert1_z;
        logic signed [31:0] vert2_x;
        logic signed [31:0] vert2_y;
        logic signed [31:0] vert2_z;
        logic               last_triangle;
    } tri_req_t;

    typedef struct packed {
        logic               segment_valid;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic               end_of_layer;
    } seg_res_t;

    // One interpolation job: base + sign * (mag_a*mag_h / mag_z)
    typedef struct packed {
        logic               neg;
        logic signed [31:0] base;
        logic [31:0]        mag_a;
        logic [31:0]        mag_h;
        logic [31:0]        mag_z;
    } interp_job_t;

    // Carried beside the four lanes
    typedef struct packed {
        logic valid;
        logic seg;
        logic last;
    } side_t;

    function automatic logic [31:0] abs33(input logic signed [32:0] v);
        logic signed [32:0] n;
        n = -v;
        return v[32] ? n[31:0] : v[31:0];
    endfunction

endpackage

/* sv/tps_edge_sel.sv */
// Classify vertices, pick the two crossing edges, build four interpolation jobs.
module tps_edge_sel
    import tps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  tri_req_t           req,
    input  logic signed [31:0] height,
    output side_t              side,
    output interp_job_t        job [4]
);
    logic signed [31:0] vx [3];
    logic signed [31:0] vy [3];
    logic signed [31:0] vz [3];
    logic [2:0]         up;
    logic [1:0]         ea;
    logic [1:0]         eb;
    logic               seg;
    side_t              side_reg, side_next;
    interp_job_t        job_reg [4];
    interp_job_t        job_next [4];

    function automatic interp_job_t mk(input logic signed [31:0] a0,
                                       input logic signed [31:0] a1,
                                       input logic signed [31:0] z0,
                                       input logic signed [31:0] z1,
                                       input logic signed [31:0] h);
        interp_job_t j;
        logic signed [32:0] da, dh, dz;
        da = 33'(a1) - 33'(a0);
        dh = 33'(h) - 33'(z0);
        dz = 33'(z1) - 33'(z0);
        j.neg   = (da[32] ^ dh[32]) ^ dz[32];
        j.base  = a0;
        j.mag_a = abs33(da);
        j.mag_h = abs33(dh);
        j.mag_z = abs33(dz);
        return j;
    endfunction

    always_comb
    begin
        vx[0] = req.vert0_x; vy[0] = req.vert0_y; vz[0] = req.vert0_z;
        vx[1] = req.vert1_x; vy[1] = req.vert1_y; vz[1] = req.vert1_z;
        vx[2] = req.vert2_x; vy[2] = req.vert2_y; vz[2] = req.vert2_z;
        for (int i = 0; i < 3; i++)
            up[i] = vz[i] >= height;
        seg = (up != 3'b000) && (up != 3'b111);
        // With a crossing, ea and eb are the pair of crossing edges, taken in index order.
        if (up[0] != up[1])
        begin
            ea = 2'd0;
            eb = (up[1] != up[2]) ? 2'd1 : 2'd2;
        end
        else
        begin
            ea = 2'd1;
            eb = 2'd2;
        end
        job_next[0] = mk(vx[ea], vx[(ea == 2'd2) ? 2'd0 : ea + 2'd1],
                         vz[ea], vz[(ea == 2'd2) ? 2'd0 : ea + 2'd1], height);
        job_next[1] = mk(vy[ea], vy[(ea == 2'd2) ? 2'd0 : ea + 2'd1],
                         vz[ea], vz[(ea == 2'd2) ? 2'd0 : ea + 2'd1], height);
        job_next[2] = mk(vx[eb], vx[(eb == 2'd2) ? 2'd0 : eb + 2'd1],
                         vz[eb], vz[(eb == 2'd2) ? 2'd0 : eb + 2'd1], height);
        job_next[3] = mk(vy[eb], vy[(eb == 2'd2) ? 2'd0 : eb + 2'd1],
                         vz[eb], vz[(eb == 2'd2) ? 2'd0 : eb + 2'd1], height);
        side_next.valid = in_valid;
        side_next.seg   = seg;
        side_next.last  = req.last_triangle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else
            side_reg <= side_next;
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    assign side = side_reg;
    assign job  = job_reg;
endmodule

/* sv/tps_interp.sv */
// Pipelined interpolation: multiply, then restoring divide BitsPerStage bits per stage.
module tps_interp
    import tps_pkg::*;
#(
    parameter int BitsPerStage = DivBits
)
(
    input  logic               clk,
    input  interp_job_t        job,
    output logic signed [31:0] result
);
    localparam int QW     = 32;
    localparam int Stages = (QW + BitsPerStage - 1) / BitsPerStage;

    // Product register
    logic [63:0]        prod_reg;
    logic [31:0]        dz_reg;
    logic               neg_reg;
    logic signed [31:0] base_reg;

    // Division stages; quotient fits 32 bits since ratio is in [0,1]
    logic [63:0]        num_reg  [Stages+1];
    logic [32:0]        rem_reg  [Stages+1];
    logic [31:0]        quo_reg  [Stages+1];
    logic [31:0]        d_reg    [Stages+1];
    logic               n_reg    [Stages+1];
    logic signed [31:0] b_reg    [Stages+1];
    logic signed [31:0] result_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(job.mag_a) * 64'(job.mag_h);
        dz_reg   <= job.mag_z;
        neg_reg  <= job.neg;
        base_reg <= job.base;
    end

    // Upper 32 product bits are below dz whenever dz is nonzero and mag_h <= dz, so seed rem.
    always_comb
    begin
        num_reg[0] = {prod_reg[31:0], 32'd0};
        rem_reg[0] = {1'b0, prod_reg[63:32]};
        quo_reg[0] = '0;
        d_reg[0]   = dz_reg;
        n_reg[0]   = neg_reg;
        b_reg[0]   = base_reg;
    end

    for (genvar s = 0; s < Stages; s++)
    begin : g_div
        logic [63:0] num_next;
        logic [32:0] rem_next;
        logic [31:0] quo_next;
        always_comb
        begin
            logic [33:0] r;
            num_next = num_reg[s];
            rem_next = rem_reg[s];
            quo_next = quo_reg[s];
            for (int k = 0; k < BitsPerStage; k++)
            begin
                r = {rem_next, num_next[63]};
                num_next = {num_next[62:0], 1'b0};
                if (d_reg[s] != 32'd0 && r >= {2'b00, d_reg[s]})
                begin
                    r = r - {2'b00, d_reg[s]};
                    quo_next = {quo_next[30:0], 1'b1};
                end
                else
                    quo_next = {quo_next[30:0], 1'b0};
                rem_next = r[32:0];
            end
        end
        always_ff @(posedge clk)
        begin
            num_reg[s+1] <= num_next;
            rem_reg[s+1] <= rem_next;
            quo_reg[s+1] <= quo_next;
            d_reg[s+1]   <= d_reg[s];
            n_reg[s+1]   <= n_reg[s];
            b_reg[s+1]   <= b_reg[s];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= n_reg[Stages] ? b_reg[Stages] - quo_reg[Stages]
                                    : b_reg[Stages] + quo_reg[Stages];
    end

    assign result = result_reg;
endmodule

/* sv/triangle_plane_slicer_top.sv */
// Channel  | Ports                   | Handshake
// request  | start, busy, req        | taken when start && !busy
// result   | done, res               | done high one cycle, no stall
// config   | cfg_we, cfg_data        | written when cfg_we
//
// Pipeline: edge select, multiply, 16 divider stages at 2 bits each, add,
// output. One request is taken every cycle; busy is tied low.
// The divider pipeline depth sets the latency. Reset clears valid bits and
// the height register; there is no stall anywhere in the pipe.
module triangle_plane_slicer_top
    import tps_pkg::*;
#(
    parameter int BitsPerStage = DivBits
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  tri_req_t           req,
    output logic               done,
    output seg_res_t           res,
    input  logic               cfg_we,
    input  logic signed [31:0] cfg_data
);
    localparam int Lat = (32 + BitsPerStage - 1) / BitsPerStage + 2;

    logic signed [31:0] height_reg;
    side_t              side;
    interp_job_t        job [4];
    logic signed [31:0] lane [4];
    side_t              side_reg [Lat];
    logic               done_reg;
    seg_res_t           res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            height_reg <= '0;
        else if (cfg_we)
            height_reg <= cfg_data;
    end

    tps_edge_sel u_sel (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .req      (req),
        .height   (height_reg),
        .side     (side),
        .job      (job)
    );

    for (genvar l = 0; l < 4; l++)
    begin : g_lane
        tps_interp #(.BitsPerStage(BitsPerStage)) u_int (
            .clk    (clk),
            .job    (job[l]),
            .result (lane[l])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Lat; i++)
                side_reg[i] <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            side_reg[0] <= side;
            for (int i = 1; i < Lat; i++)
                side_reg[i] <= side_reg[i-1];
            done_reg <= side_reg[Lat-1].valid;
        end
    end

    always_comb
    begin
        res_next.segment_valid = side_reg[Lat-1].seg;
        res_next.start_x       = side_reg[Lat-1].seg ? lane[0] : '0;
        res_next.start_y       = side_reg[Lat-1].seg ? lane[1] : '0;
        res_next.end_x         = side_reg[Lat-1].seg ? lane[2] : '0;
        res_next.end_y         = side_reg[Lat-1].seg ? lane[3] : '0;
        res_next.end_of_layer  = side_reg[Lat-1].last;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy = 1'b0;
    assign done = done_reg;
    assign res  = res_reg;

`ifndef NO_ASSERTIONS
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        side_reg[Lat-1].valid |=> done)
        else $error("done lost");
    a_zero_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done && !res.segment_valid |-> res.start_x == 0 && res.end_y == 0)
        else $error("nonzero ends without segment");
`endif
endmodule
